// File: rtl/lea_pkg.sv
`default_nettype none

package lea_pkg;

  // block fields
  localparam int WORD_W  = 32;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int CFG_W   = 6;

  // six round-key words per round, stored one round per row
  localparam int LANES   = 6;
  localparam int LANE_W  = 3;
  localparam int ROW_W   = 6;   // round/row counter, wide enough to step past 32
  localparam int RND_W   = 5;   // round index 0..31

  // round-count decode
  localparam logic [CFG_W-1:0] RC_BASE  = 6'd24;
  localparam logic [CFG_W-1:0] RC_MID   = 6'd28;
  localparam logic [RND_W-1:0] LAST_24  = 5'd23;
  localparam logic [RND_W-1:0] LAST_28  = 5'd27;
  localparam logic [RND_W-1:0] LAST_32  = 5'd31;

  // floor(idx / 6) = (idx * 171) >> 10, exact for any 8-bit idx
  localparam int DIV6_MUL   = 171;
  localparam int DIV6_SHIFT = 10;
  localparam int PROD_W     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_KEY = 2'd0,
    OP_ENC = 2'd1,
    OP_DEC = 2'd2
  } opcode_e;

  // decrypt round is split in three dependent sub-steps
  typedef enum logic [1:0] {
    PH_SUB1 = 2'd0,
    PH_SUB2 = 2'd1,
    PH_SUB3 = 2'd2
  } phase_e;

  typedef struct packed {
    logic             key_wr;      // write key word from input beat
    logic             load_block;  // capture input block
    logic             key_load;    // read key row into key register
    logic             enc_step;    // one encrypt round
    logic             dec_step;    // one decrypt sub-step
    phase_e           phase;
    logic [ROW_W-1:0] rd_row;
    logic             out_load;    // move working block into output register
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/lea_ctrl.sv
`default_nettype none

module lea_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [lea_pkg::OP_W-1:0]  opcode_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [lea_pkg::CFG_W-1:0] cfg_data_i,
  output lea_pkg::cmd_t                  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_ENC,
    ST_DEC,
    ST_DONE
  } state_e;

  state_e                        state_q;
  logic                          dec_q;
  logic [lea_pkg::RND_W-1:0]     cnt_q;
  lea_pkg::phase_e               phase_q;
  logic [lea_pkg::ROW_W-1:0]     row_q;
  logic                          out_valid_q;
  logic [lea_pkg::CFG_W-1:0]     rc_q;

  logic                          accept;
  logic                          out_free;
  logic [lea_pkg::RND_W-1:0]     last_rnd;
  lea_pkg::opcode_e              op;

  assign op          = lea_pkg::opcode_e'(opcode_i);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    last_rnd = lea_pkg::LAST_24;
    if (rc_q > lea_pkg::RC_BASE) last_rnd = lea_pkg::LAST_28;
    if (rc_q > lea_pkg::RC_MID)  last_rnd = lea_pkg::LAST_32;
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.key_wr     = accept && (op == lea_pkg::OP_KEY);
    cmd_o.load_block = accept && ((op == lea_pkg::OP_ENC) || (op == lea_pkg::OP_DEC));
    cmd_o.key_load   = (state_q == ST_PRIME) || (state_q == ST_ENC) ||
                       ((state_q == ST_DEC) && (phase_q == lea_pkg::PH_SUB3));
    cmd_o.enc_step   = (state_q == ST_ENC);
    cmd_o.dec_step   = (state_q == ST_DEC);
    cmd_o.phase      = phase_q;
    cmd_o.rd_row     = row_q;
    cmd_o.out_load   = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dec_q       <= 1'b0;
      cnt_q       <= '0;
      phase_q     <= lea_pkg::PH_SUB1;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      rc_q        <= lea_pkg::RC_BASE;
    end else begin
      if (cfg_valid_i) rc_q <= cfg_data_i;
      // output register fills from the done state, empties when taken
      if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)               out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          cnt_q   <= '0;
          phase_q <= lea_pkg::PH_SUB1;
          if (accept) begin
            case (op)
              lea_pkg::OP_ENC: begin
                dec_q   <= 1'b0;
                row_q   <= '0;
                state_q <= ST_PRIME;
              end
              lea_pkg::OP_DEC: begin
                dec_q   <= 1'b1;
                row_q   <= lea_pkg::ROW_W'(last_rnd);
                state_q <= ST_PRIME;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_PRIME: begin
          row_q   <= dec_q ? row_q - 1'b1 : row_q + 1'b1;
          state_q <= dec_q ? ST_DEC : ST_ENC;
        end
        ST_ENC: begin
          row_q <= row_q + 1'b1;
          if (cnt_q == last_rnd) state_q <= ST_DONE;
          else                   cnt_q   <= cnt_q + 1'b1;
        end
        ST_DEC: begin
          case (phase_q)
            lea_pkg::PH_SUB1: phase_q <= lea_pkg::PH_SUB2;
            lea_pkg::PH_SUB2: phase_q <= lea_pkg::PH_SUB3;
            default: begin
              phase_q <= lea_pkg::PH_SUB1;
              row_q   <= row_q - 1'b1;
              if (cnt_q == last_rnd) state_q <= ST_DONE;
              else                   cnt_q   <= cnt_q + 1'b1;
            end
          endcase
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/lea_datapath.sv
`default_nettype none

module lea_datapath #(
  parameter int KEY_WORDS = 192
) (
  input  wire logic                       clk_i,
  input  wire lea_pkg::cmd_t              cmd_i,
  input  wire logic [lea_pkg::IDX_W-1:0]  key_index_i,
  input  wire logic [lea_pkg::WORD_W-1:0] key_word_i,
  input  wire logic [lea_pkg::WORD_W-1:0] block_in_w0_i,
  input  wire logic [lea_pkg::WORD_W-1:0] block_in_w1_i,
  input  wire logic [lea_pkg::WORD_W-1:0] block_in_w2_i,
  input  wire logic [lea_pkg::WORD_W-1:0] block_in_w3_i,
  output logic      [lea_pkg::WORD_W-1:0] block_out_w0_o,
  output logic      [lea_pkg::WORD_W-1:0] block_out_w1_o,
  output logic      [lea_pkg::WORD_W-1:0] block_out_w2_o,
  output logic      [lea_pkg::WORD_W-1:0] block_out_w3_o
);

  localparam int NUM_ROWS = (KEY_WORDS + lea_pkg::LANES - 1) / lea_pkg::LANES;
  localparam int ADDR_W   = $clog2(NUM_ROWS);
  localparam int CHK_W    = 9;

  // key store: one row of six words per round
  logic [lea_pkg::WORD_W-1:0] key_mem [NUM_ROWS][lea_pkg::LANES];
  logic [lea_pkg::WORD_W-1:0] key_rd_q [lea_pkg::LANES];
  logic [lea_pkg::ROW_W-1:0]  rd_row_q;
  logic [lea_pkg::WORD_W-1:0] k [lea_pkg::LANES];

  logic [lea_pkg::WORD_W-1:0] x0_q, x1_q, x2_q, x3_q;
  logic [lea_pkg::WORD_W-1:0] x0_d, x1_d, x2_d, x3_d;
  logic [lea_pkg::WORD_W-1:0] out0_q, out1_q, out2_q, out3_q;

  logic [lea_pkg::PROD_W-1:0] wr_prod;
  logic [lea_pkg::ROW_W-1:0]  wr_row;
  logic [lea_pkg::IDX_W-1:0]  wr_rem;
  logic [lea_pkg::LANE_W-1:0] wr_lane;
  logic                       wr_ok;
  logic [ADDR_W-1:0]          rd_addr;

  logic [lea_pkg::WORD_W-1:0] s0, s1, s2, d;

  // key write address: row = idx / 6, lane = idx % 6
  assign wr_prod = lea_pkg::PROD_W'(key_index_i) * lea_pkg::PROD_W'(lea_pkg::DIV6_MUL);
  assign wr_row  = lea_pkg::ROW_W'(wr_prod >> lea_pkg::DIV6_SHIFT);
  assign wr_rem  = key_index_i - lea_pkg::IDX_W'(wr_row) * lea_pkg::IDX_W'(lea_pkg::LANES);
  assign wr_lane = wr_rem[lea_pkg::LANE_W-1:0];
  assign wr_ok   = key_index_i < lea_pkg::IDX_W'(KEY_WORDS);

  // rows past the store read as zero through the lane mask below
  assign rd_addr = (cmd_i.rd_row < lea_pkg::ROW_W'(NUM_ROWS)) ?
                   cmd_i.rd_row[ADDR_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr && wr_ok) key_mem[wr_row[ADDR_W-1:0]][wr_lane] <= key_word_i;
    if (cmd_i.key_load) begin
      key_rd_q <= key_mem[rd_addr];
      rd_row_q <= cmd_i.rd_row;
    end
  end

  always_comb begin
    for (int j = 0; j < lea_pkg::LANES; j++) begin
      k[j] = ((CHK_W'(rd_row_q) * CHK_W'(lea_pkg::LANES) + CHK_W'(j)) < CHK_W'(KEY_WORDS)) ?
             key_rd_q[j] : '0;
    end
  end

  always_comb begin
    x0_d = x0_q;
    x1_d = x1_q;
    x2_d = x2_q;
    x3_d = x3_q;
    s0   = (x0_q ^ k[0]) + (x1_q ^ k[1]);
    s1   = (x1_q ^ k[2]) + (x2_q ^ k[3]);
    s2   = (x2_q ^ k[4]) + (x3_q ^ k[5]);
    d    = '0;
    if (cmd_i.load_block) begin
      x0_d = block_in_w0_i;
      x1_d = block_in_w1_i;
      x2_d = block_in_w2_i;
      x3_d = block_in_w3_i;
    end else if (cmd_i.enc_step) begin
      x0_d = {s0[22:0], s0[31:23]};   // rol 9
      x1_d = {s1[4:0],  s1[31:5]};    // ror 5
      x2_d = {s2[2:0],  s2[31:3]};    // ror 3
      x3_d = x0_q;
    end else if (cmd_i.dec_step) begin
      case (cmd_i.phase)
        lea_pkg::PH_SUB1: begin
          // p1 lands in x0 (old x0 no longer needed)
          d    = {x0_q[8:0], x0_q[31:9]} - (x3_q ^ k[0]);
          x0_d = d ^ k[1];
        end
        lea_pkg::PH_SUB2: begin
          d    = {x1_q[26:0], x1_q[31:27]} - (x0_q ^ k[2]);
          x1_d = d ^ k[3];
        end
        default: begin
          d    = {x2_q[28:0], x2_q[31:29]} - (x1_q ^ k[4]);
          x0_d = x3_q;
          x1_d = x0_q;
          x2_d = x1_q;
          x3_d = d ^ k[5];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= x0_d;
    x1_q <= x1_d;
    x2_q <= x2_d;
    x3_q <= x3_d;
    if (cmd_i.out_load) begin
      out0_q <= x0_q;
      out1_q <= x1_q;
      out2_q <= x2_q;
      out3_q <= x3_q;
    end
  end

  assign block_out_w0_o = out0_q;
  assign block_out_w1_o = out1_q;
  assign block_out_w2_o = out2_q;
  assign block_out_w3_o = out3_q;

endmodule

`default_nettype wire

// File: rtl/lea_block_cipher_core.sv
`default_nettype none

// Channel   Direction  Handshake                 Beat contents
// in        sink       in_valid_i / in_stall_o   opcode, key_index, key_word, block_in_w0..w3
// out       source     out_valid_o / out_stall_i block_out_w0..w3
// cfg       sink       cfg_valid_i / cfg_ready_o round_count (cfg_data_i)
//
// Key write beat: written into the key store at the accepting edge.
// Encrypt: N rounds (N = 24, 28 or 32), one round per cycle, set by
//   the six-word key row read each round from the store.
// Decrypt: each round runs as three dependent subtract steps.
// The finished block sits in the output register, so a new beat is taken while
//   it waits; the engine holds in its done state only if that register is full and stalled.
// Reset clears control and round_count (24); the key store is not cleared.

module lea_block_cipher_core #(
  parameter int KEY_WORDS = 192
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [lea_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [lea_pkg::IDX_W-1:0]  key_index_i,
  input  wire logic [lea_pkg::WORD_W-1:0] key_word_i,
  input  wire logic [lea_pkg::WORD_W-1:0] block_in_w0_i,
  input  wire logic [lea_pkg::WORD_W-1:0] block_in_w1_i,
  input  wire logic [lea_pkg::WORD_W-1:0] block_in_w2_i,
  input  wire logic [lea_pkg::WORD_W-1:0] block_in_w3_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [lea_pkg::WORD_W-1:0] block_out_w0_o,
  output logic      [lea_pkg::WORD_W-1:0] block_out_w1_o,
  output logic      [lea_pkg::WORD_W-1:0] block_out_w2_o,
  output logic      [lea_pkg::WORD_W-1:0] block_out_w3_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [lea_pkg::CFG_W-1:0]  cfg_data_i
);

  lea_pkg::cmd_t cmd;

  // sequencer: handshakes, round counting, key row addressing
  lea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd)
  );

  // key store, round logic and output register
  lea_datapath #(
    .KEY_WORDS (KEY_WORDS)
  ) u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .key_index_i    (key_index_i),
    .key_word_i     (key_word_i),
    .block_in_w0_i  (block_in_w0_i),
    .block_in_w1_i  (block_in_w1_i),
    .block_in_w2_i  (block_in_w2_i),
    .block_in_w3_i  (block_in_w3_i),
    .block_out_w0_o (block_out_w0_o),
    .block_out_w1_o (block_out_w1_o),
    .block_out_w2_o (block_out_w2_o),
    .block_out_w3_o (block_out_w3_o)
  );

endmodule

`default_nettype wire
